FILE: src/lennard_jones_pair_energy_top_macros.svh
// Assertion macros shared by the pair energy block.
`ifndef LENNARD_JONES_PAIR_ENERGY_TOP_MACROS_SVH
`define LENNARD_JONES_PAIR_ENERGY_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LJ_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LJ_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LJ_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons)
`define LJ_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif
`endif

FILE: src/ljpe_pkg.sv
// ----------------------------------------------------------------------------
// ljpe_pkg
// Types and constants shared by the pair energy block.
// ----------------------------------------------------------------------------
`default_nettype none
package ljpe_pkg;
  localparam int CFG_W = 28;
  localparam int CFG_IDX_LOW = 0;
  localparam int CFG_IDX_HIGH = 1;
  localparam logic [CFG_W-1:0] LOW_RESET = 28'd3427652;
  localparam logic [CFG_W-1:0] HIGH_RESET = 28'd16777216;
  localparam int E_W = 48;
  localparam int S_W = 56;
  localparam logic [63:0] TERM_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SQ, ST_WIN, ST_DIV, ST_MLOAD, ST_MUL, ST_SUB, ST_RD, ST_ACC,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_I4, MS_I6, MS_I12, MS_T6, MS_T12
  } mstep_t;
endpackage
`default_nettype wire

FILE: src/ljpe_ram.sv
// ----------------------------------------------------------------------------
// ljpe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ljpe_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: src/ljpe_div.sv
// ----------------------------------------------------------------------------
// ljpe_div
// Restoring divider computing 2^48 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ljpe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [48:0]      quotient
);
  logic [6:0]  cnt;
  logic        busy;
  logic [63:0] rem;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    shifted = {rem, (cnt == 7'd48)};
    trial = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd48;
        rem <= '0;
        quotient <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
        end else begin
          rem <= shifted[63:0];
        end
        quotient <= {quotient[47:0], ~trial[64]};
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/ljpe_mul.sv
// ----------------------------------------------------------------------------
// ljpe_mul
// Shared 64x64 multiplier built from 32x32 partial products accumulated in turn,
// giving floor(a*b / 2^sh) saturated at 2^62-1.
// ----------------------------------------------------------------------------
`default_nettype none
module ljpe_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic        sh32,
  output logic             done,
  output logic [63:0]      result
);
  import ljpe_pkg::*;
  logic [2:0]   ph;
  logic         busy;
  logic [63:0]  ra, rb;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [31:0]  opa, opb;
  logic [127:0] term;
  logic [127:0] full;
  logic [127:0] sh;

  always_comb begin
    opa = ph[1] ? ra[63:32] : ra[31:0];
    opb = ph[0] ? rb[63:32] : rb[31:0];
    pp = opa * opb;
    term = {64'd0, pp} << (7'(ph[1]) * 7'd32 + 7'(ph[0]) * 7'd32);
    full = acc + term;
    sh = sh32 ? (full >> 32) : (full >> 24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph <= '0;
        ra <= a;
        rb <= b;
        acc <= '0;
      end else if (busy) begin
        acc <= full;
        ph <= ph + 3'd1;
        if (ph == 3'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
          result <= (sh > {64'd0, TERM_CAP}) ? TERM_CAP : sh[63:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/lennard_jones_pair_energy_top.sv
// Steps: a counted evaluate runs squaring, window check, divider, five multiplies,
// then subtract, read, accumulate and output; an evaluate outside the window skips
// the divider, multiplies and subtract; a read or a same-residue evaluate goes
// straight to read, accumulate and output. Throughput: one request at a time; the
// next is taken only after the result is accepted. After reset a clearing pass
// zeroes every accumulator memory entry before the first request.
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_top
// Lennard-Jones 12-6 pair energy with saturating per-residue-pair sums.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lennard_jones_pair_energy_top_macros.svh"
module lennard_jones_pair_energy_top #(
  parameter int RESIDUES = 32,
  parameter int COORD_FRAC_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ljpe_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        valid,
  output logic                             ready,
  input  wire logic                        cmd,
  input  wire logic [4:0]                  res_first,
  input  wire logic [4:0]                  res_second,
  input  wire logic signed [19:0]          x_first,
  input  wire logic signed [19:0]          y_first,
  input  wire logic signed [19:0]          z_first,
  input  wire logic signed [19:0]          x_second,
  input  wire logic signed [19:0]          y_second,
  input  wire logic signed [19:0]          z_second,
  input  wire logic [31:0]                 coef_six,
  input  wire logic [31:0]                 coef_twelve,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [ljpe_pkg::E_W-1:0]  pair_energy,
  output logic                             counted,
  output logic signed [ljpe_pkg::S_W-1:0]  residue_sum
);
  import ljpe_pkg::*;
  localparam int DEPTH = RESIDUES * RESIDUES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FB2 = 2 * COORD_FRAC_BITS;

  state_t state, state_next;
  mstep_t mstep;
  logic [CFG_W-1:0] cut_low, cut_high;
  logic [AW-1:0] clr_addr;
  logic r_cmd, addr_ok;
  logic [AW-1:0] idx;
  logic signed [20:0] dd [3];
  logic [1:0] sq_cnt;
  logic [42:0] r2;
  logic [63:0] s_val;
  logic [31:0] c6, c12;
  logic [63:0] inv2, inv4, inv6, inv12, t6;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [S_W-1:0] ram_wdata, ram_rdata;
  logic div_start, div_done, mul_start, mul_done;
  logic [48:0] quo;
  logic [63:0] mul_a, mul_b, mul_res;
  logic mul_sh32;
  logic signed [20:0] dsel;
  logic [41:0] dsq;
  logic signed [65:0] ediff;
  logic signed [S_W:0] asum;

  ljpe_ram #(.WIDTH(S_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );
  ljpe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(s_val),
    .done(div_done), .quotient(quo)
  );
  ljpe_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .sh32(mul_sh32), .done(mul_done), .result(mul_res)
  );

  always_comb begin
    dsel = dd[sq_cnt];
    dsq = 42'(dsel * dsel);
    if (FB2 >= 24) begin
      s_val = 64'({21'd0, r2} >> (FB2 - 24));
    end else begin
      s_val = 64'({21'd0, r2} << (24 - FB2));
    end
    ediff = $signed({2'b0, mul_res}) - $signed({2'b0, t6});
    asum = $signed({ram_rdata[S_W-1], ram_rdata})
         + $signed({{(S_W-E_W+1){pair_energy[E_W-1]}}, pair_energy});
    case (mstep)
      MS_I4:   begin mul_a = inv2; mul_b = inv2; end
      MS_I6:   begin mul_a = inv4; mul_b = inv2; end
      MS_I12:  begin mul_a = inv6; mul_b = inv6; end
      MS_T6:   begin mul_a = {32'd0, c6}; mul_b = inv6; end
      MS_T12:  begin mul_a = {32'd0, c12}; mul_b = inv12; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_sh32 = (mstep == MS_T6) || (mstep == MS_T12);
  end

  always_comb begin
    state_next = state;
    ready = 1'b0;
    ram_we = 1'b0;
    ram_addr = idx;
    ram_wdata = '0;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ready = !out_valid;
        if (valid && ready) begin
          state_next = (cmd == CMD_READ || res_first == res_second) ? ST_RD : ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_cnt == 2'd2) begin
          state_next = ST_WIN;
        end
      end
      ST_WIN: begin
        if (s_val > {36'd0, cut_low} && s_val < {36'd0, cut_high}) begin
          if (s_val == 64'd0) begin
            state_next = ST_RD;
          end else begin
            div_start = 1'b1;
            state_next = ST_DIV;
          end
        end else begin
          state_next = ST_RD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MLOAD;
        end
      end
      ST_MLOAD: begin
        mul_start = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (mstep == MS_T12) begin
            state_next = ST_SUB;
          end else begin
            state_next = ST_MLOAD;
          end
        end
      end
      ST_SUB: state_next = ST_RD;
      ST_RD: state_next = ST_ACC;
      ST_ACC: begin
        if (addr_ok) begin
          if (r_cmd == CMD_READ) begin
            ram_we = 1'b1;
          end else if (counted) begin
            ram_we = 1'b1;
            if (asum > $signed({2'b00, {(S_W-1){1'b1}}})) begin
              ram_wdata = {1'b0, {(S_W-1){1'b1}}};
            end else if (asum < $signed({2'b11, {(S_W-1){1'b0}}})) begin
              ram_wdata = {1'b1, {(S_W-1){1'b0}}};
            end else begin
              ram_wdata = asum[S_W-1:0];
            end
          end
        end
        state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      cut_low <= LOW_RESET;
      cut_high <= HIGH_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_IDX_LOW)) begin
          cut_low <= cfg_data;
        end else if (cfg_index == 1'(CFG_IDX_HIGH)) begin
          cut_high <= cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_OUT) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (valid && ready) begin
          r_cmd <= cmd;
          addr_ok <= (32'(res_first) < RESIDUES) && (32'(res_second) < RESIDUES);
          idx <= AW'(32'(res_first) * RESIDUES + 32'(res_second));
          dd[0] <= 21'(x_first) - 21'(x_second);
          dd[1] <= 21'(y_first) - 21'(y_second);
          dd[2] <= 21'(z_first) - 21'(z_second);
          c6 <= coef_six;
          c12 <= coef_twelve;
          sq_cnt <= '0;
          r2 <= '0;
          pair_energy <= '0;
          counted <= 1'b0;
          mstep <= MS_I4;
        end
      end
      ST_SQ: begin
        r2 <= r2 + {1'b0, dsq};
        sq_cnt <= sq_cnt + 2'd1;
      end
      ST_WIN: begin
        if (s_val > {36'd0, cut_low} && s_val < {36'd0, cut_high}) begin
          counted <= 1'b1;
          if (s_val == 64'd0) begin
            pair_energy <= {1'b0, {(E_W-1){1'b1}}};
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          inv2 <= {15'd0, quo};
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          case (mstep)
            MS_I4:   begin inv4 <= mul_res; mstep <= MS_I6; end
            MS_I6:   begin inv6 <= mul_res; mstep <= MS_I12; end
            MS_I12:  begin inv12 <= mul_res; mstep <= MS_T6; end
            MS_T6:   begin t6 <= mul_res; mstep <= MS_T12; end
            default: mstep <= MS_T12;
          endcase
        end
      end
      ST_SUB: begin
        if (ediff > $signed({18'd0, {(E_W-1){1'b1}}})) begin
          pair_energy <= {1'b0, {(E_W-1){1'b1}}};
        end else if (ediff < -$signed({18'd0, 1'b1, {(E_W-1){1'b0}}})) begin
          pair_energy <= {1'b1, {(E_W-1){1'b0}}};
        end else begin
          pair_energy <= ediff[E_W-1:0];
        end
      end
      ST_ACC: begin
        if (!addr_ok) begin
          residue_sum <= '0;
        end else if (r_cmd == CMD_READ) begin
          residue_sum <= ram_rdata;
        end else begin
          residue_sum <= ram_we ? ram_wdata : ram_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  `LJ_ASSERT_IMP(a_ready_idle, clk, rst, ready, state == ST_IDLE)
  `LJ_ASSERT_IMP(a_read_uncounted, clk, rst, out_valid && r_cmd == CMD_READ, !counted)
  `LJ_ASSERT_IMP(a_zero_uncounted, clk, rst, out_valid && !counted, pair_energy == '0)
  `LJ_ASSERT_NEXT(a_out_follows, clk, rst, state == ST_OUT, out_valid)
endmodule
`default_nettype wire
